[rtl/mlst_pkg.sv]
// ----------------------------------------------------------------------------
// mlst_pkg
// Shared constants, codes and types of the multi-level sparse table.
// ----------------------------------------------------------------------------
package mlst_pkg;

	localparam int NODE_COUNT    = 64;
	localparam int MAX_SLOT_BITS = 8;
	localparam int VALUE_BITS    = 32;
	localparam int KEY_BITS      = 32;
	localparam int CFG_LEVELS    = 4;

	localparam int STORE_DEPTH = NODE_COUNT << MAX_SLOT_BITS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int NIU_W       = $clog2(NODE_COUNT + 1);
	localparam int LVL_W       = $clog2(CFG_LEVELS);
	localparam int LCNT_W      = 3;
	localparam int BITS_W      = 4;
	localparam int TOTAL_W     = 6;
	localparam int CIDX_W      = 3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_LEVEL_COUNT  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BITS_FIRST   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_BITS_SECOND  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_BITS_THIRD   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_BITS_FOURTH  = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_POOL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [LCNT_W-1:0]                   lvl_cnt;
		logic [CFG_LEVELS-1:0][BITS_W-1:0]   bits;
		logic [TOTAL_W-1:0]                  total;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd;
		logic wr_leaf;
		logic take;
		logic descend;
		logic link;
		logic mark_oor;
		logic mark_full;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic oor;
		logic is_set;
		logic at_leaf;
		logic child_ok;
		logic pool_full;
		logic out_busy;
	} sts_t;

endpackage

[rtl/mlst_cfg.sv]
// ----------------------------------------------------------------------------
// mlst_cfg
// Level configuration registers with range clamping and total key width.
// ----------------------------------------------------------------------------
module mlst_cfg
	import mlst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CIDX_W-1:0] wr_index,
	input  logic [BITS_W-1:0] wr_data,
	output cfg_t              cfg,
	output logic              clr
);

	logic [LCNT_W-1:0]                 lvl_cnt_q;
	logic [CFG_LEVELS-1:0][BITS_W-1:0] bits_q;
	logic [LCNT_W-1:0]                 cnt_sat;
	logic [BITS_W-1:0]                 bits_sat;
	logic [TOTAL_W-1:0]                total;

	// clamp into 1..4 levels and 1..MAX_SLOT_BITS bits
	always_comb begin
		cnt_sat = wr_data[LCNT_W-1:0];
		if (cnt_sat == '0)
			cnt_sat = LCNT_W'(1);
		else if (cnt_sat > LCNT_W'(CFG_LEVELS))
			cnt_sat = LCNT_W'(CFG_LEVELS);
		bits_sat = wr_data;
		if (bits_sat == '0)
			bits_sat = BITS_W'(1);
		else if (bits_sat > BITS_W'(MAX_SLOT_BITS))
			bits_sat = BITS_W'(MAX_SLOT_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_cnt_q <= LCNT_W'(3);
			bits_q[0] <= BITS_W'(5);
			bits_q[1] <= BITS_W'(8);
			bits_q[2] <= BITS_W'(8);
			bits_q[3] <= BITS_W'(8);
		end else if (wr_en) begin
			case (wr_index)
				CFG_LEVEL_COUNT: lvl_cnt_q <= cnt_sat;
				CFG_BITS_FIRST:  bits_q[0] <= bits_sat;
				CFG_BITS_SECOND: bits_q[1] <= bits_sat;
				CFG_BITS_THIRD:  bits_q[2] <= bits_sat;
				CFG_BITS_FOURTH: bits_q[3] <= bits_sat;
				default: ;
			endcase
		end
	end

	always_comb begin
		total = '0;
		for (int l = 0; l < CFG_LEVELS; l++) begin
			if (LCNT_W'(l) < lvl_cnt_q)
				total = total + TOTAL_W'(bits_q[l]);
		end
	end

	assign clr = wr_en && (wr_index <= CFG_BITS_FOURTH);

	assign cfg.lvl_cnt = lvl_cnt_q;
	assign cfg.bits    = bits_q;
	assign cfg.total   = total;

endmodule

[rtl/mlst_ctrl.sv]
// ----------------------------------------------------------------------------
// mlst_ctrl
// Walk sequencer: clearing pass, range check, per-level read and decide.
// ----------------------------------------------------------------------------
module mlst_ctrl
	import mlst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_CHECK = 6'b000100,
		S_READ  = 6'b001000,
		S_EVAL  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.oor) begin
					cmd.mark_oor = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.at_leaf && sts.is_set) begin
					cmd.wr_leaf = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.at_leaf) begin
					cmd.take = 1'b1;
					state_d  = S_DONE;
				end else if (sts.child_ok) begin
					cmd.descend = 1'b1;
					state_d     = S_READ;
				end else if (!sts.is_set) begin
					state_d = S_DONE;
				end else if (sts.pool_full) begin
					cmd.mark_full = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.link = 1'b1;
					state_d  = S_READ;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else if (clr)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

[rtl/mlst_dp.sv]
// ----------------------------------------------------------------------------
// mlst_dp
// Node store, walk registers, node pool counter and result register.
// ----------------------------------------------------------------------------
module mlst_dp
	import mlst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  cfg_t                  cfg,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  in_set,
	input  logic [KEY_BITS-1:0]   in_key,
	input  logic [VALUE_BITS-1:0] in_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] out_value,
	output status_t               out_status
);

	logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;

	logic                  set_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [LVL_W-1:0]      level_q;
	logic [NODE_W-1:0]     node_q;
	logic [TOTAL_W-1:0]    rem_q;
	logic [VALUE_BITS-1:0] wval_q;
	status_t               wst_q;
	logic [NIU_W-1:0]      niu_q;
	logic [STORE_AW-1:0]   clr_cnt_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	status_t               out_status_q;

	logic [BITS_W-1:0]        b_cur;
	logic [BITS_W-1:0]        b_next;
	logic [KEY_BITS-1:0]      key_sh;
	logic [MAX_SLOT_BITS-1:0] slot_mask;
	logic [MAX_SLOT_BITS-1:0] slot;
	logic [STORE_AW-1:0]      addr;
	logic                     mem_we;
	logic [STORE_AW-1:0]      mem_waddr;
	logic [VALUE_BITS-1:0]    mem_wdata;
	logic                     advance;

	// slot index of the current level
	assign b_cur     = cfg.bits[level_q];
	assign b_next    = cfg.bits[level_q + LVL_W'(1)];
	assign key_sh    = key_q >> rem_q;
	assign slot_mask = {MAX_SLOT_BITS{1'b1}} >> (BITS_W'(MAX_SLOT_BITS) - b_cur);
	assign slot      = key_sh[MAX_SLOT_BITS-1:0] & slot_mask;
	assign addr      = {node_q, slot};

	assign advance = cmd.descend || cmd.link;

	always_comb begin
		mem_we    = cmd.clr_step || cmd.wr_leaf || cmd.link;
		mem_waddr = addr;
		mem_wdata = val_q;
		if (cmd.clr_step) begin
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (cmd.link) begin
			mem_wdata = VALUE_BITS'(niu_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (cmd.rd)
			rdata_q <= mem[addr];
	end

	// walk and result registers, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_q   <= in_set;
			key_q   <= in_key;
			val_q   <= in_value;
			level_q <= '0;
			node_q  <= '0;
			rem_q   <= cfg.total - TOTAL_W'(cfg.bits[0]);
			wval_q  <= '0;
			wst_q   <= ST_OK;
		end else begin
			if (advance) begin
				level_q <= level_q + LVL_W'(1);
				rem_q   <= rem_q - TOTAL_W'(b_next);
			end
			if (cmd.descend)
				node_q <= rdata_q[NODE_W-1:0];
			if (cmd.link)
				node_q <= niu_q[NODE_W-1:0];
			if (cmd.take && !set_q)
				wval_q <= rdata_q;
			if (cmd.mark_oor)
				wst_q <= ST_RANGE;
			if (cmd.mark_full)
				wst_q <= ST_POOL;
		end
		if (cmd.emit) begin
			out_value_q  <= wval_q;
			out_status_q <= wst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			niu_q       <= NIU_W'(1);
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				niu_q     <= NIU_W'(1);
				clr_cnt_q <= '0;
			end else begin
				if (cmd.link)
					niu_q <= niu_q + NIU_W'(1);
				if (cmd.clr_step)
					clr_cnt_q <= clr_cnt_q + STORE_AW'(1);
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.clr_done  = (clr_cnt_q == '1);
	assign sts.oor       = (key_q >> cfg.total) != '0;
	assign sts.is_set    = set_q;
	assign sts.at_leaf   = (LCNT_W'(level_q) + LCNT_W'(1)) == cfg.lvl_cnt;
	assign sts.child_ok  = (rdata_q != '0) && (rdata_q[VALUE_BITS-1:NODE_W] == '0);
	assign sts.pool_full = (niu_q == NIU_W'(NODE_COUNT));
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

[rtl/multi_level_sparse_table.sv]
// ----------------------------------------------------------------------------
// multi_level_sparse_table
// Sparse table held as a radix tree of one to four levels in one node store.
// ----------------------------------------------------------------------------
// Sequence: an input transfer is range-checked, then each level of the walk
//   reads the node store (registered read) and decides; range errors skip the
//   walk, and a set that reaches the leaf writes it without the decide step.
// A new transfer is taken only after the last result is loaded into the result
//   register; the load waits while an earlier result is still held unaccepted.
// Reset and every write to a listed register start a clearing pass over all
//   16384 words of the node store; no input transfer is taken until it ends.
// ----------------------------------------------------------------------------
module multi_level_sparse_table
	import mlst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,    // [31:0] lookup_key, [63:32] write_value
	input  logic              s_tuser,    // [0] req_type
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,    // [31:0] read_value
	output logic [1:0]        m_tuser,    // [1:0] status
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [BITS_W-1:0] cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	sts_t    sts;
	logic    clr;
	status_t out_status;

	// registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	// hold level widths; flag a table clear on every listed register
	mlst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.clr      (clr)
	);

	// sequence the clearing pass and the level walk
	mlst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// node store, walk state and result register; the result waits here
	// while the controller goes back for the next transfer
	mlst_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (clr),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.in_set     (s_tuser),
		.in_key     (s_tdata[31:0]),
		.in_value   (s_tdata[63:32]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (out_status)
	);

	assign m_tuser = out_status;

endmodule
